// ===== src/sdt_pkg.sv =====
// Shared types and constants for the set deduplication table.
// No dependencies; used by sdt_builder, sdt_cell and set_dedup_table.
package sdt_pkg;

  // Member count width and its saturation value.
  localparam int unsigned COUNT_W = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // Width of the set number carried on the result channel.
  localparam int unsigned NUM_W = 5;

  // Entry numbers along the cell chain; wide enough for the deepest table.
  localparam int unsigned ENTRY_W = 8;

  // Controller states.
  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_LOOKUP,
    ST_RESOLVE
  } state_t;

  // Priority token handed from cell to cell: lowest matching entry wins.
  typedef struct packed {
    logic               found;
    logic [ENTRY_W-1:0] number;
  } chain_t;

endpackage

// ===== src/sdt_builder.sv =====
// Accumulates the membership bitmap and saturating member count of a group.
// Depends on sdt_pkg.
module sdt_builder #(
  parameter int unsigned MEMBER_LIMIT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          beat,
  input  logic [5:0]                    member_index,
  input  logic                          clear,
  output logic [MEMBER_LIMIT-1:0]       bitmap,
  output logic [sdt_pkg::COUNT_W-1:0]   count
);

  logic [MEMBER_LIMIT-1:0]     bitmap_next;
  logic [sdt_pkg::COUNT_W-1:0] count_next;

  // Indices at or above the limit match no bit but still count.
  always_comb begin
    for (int j = 0; j < MEMBER_LIMIT; j++) begin
      bitmap_next[j] = bitmap[j] | (member_index == 6'(j));
    end
    count_next = (count == sdt_pkg::COUNT_MAX) ? count : count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      bitmap <= '0;
      count  <= '0;
    end else if (beat) begin
      bitmap <= bitmap_next;
      count  <= count_next;
    end
  end

endmodule

// ===== src/sdt_cell.sv =====
// One table entry: stored bitmap and count, a registered compare against the
// search key, and one link of the lowest-match priority chain. Depends on sdt_pkg.
module sdt_cell #(
  parameter int unsigned MEMBER_LIMIT = 64,
  parameter int unsigned CELL_INDEX   = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [MEMBER_LIMIT-1:0]       key_bitmap,
  input  logic [sdt_pkg::COUNT_W-1:0]   key_count,
  input  logic                          write_en,
  input  sdt_pkg::chain_t               chain_in,
  output sdt_pkg::chain_t               chain_out
);

  logic                        valid;
  logic                        hit;
  logic [MEMBER_LIMIT-1:0]     bitmap;
  logic [sdt_pkg::COUNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (write_en) begin
        valid <= 1'b1;
      end
      hit <= valid && (bitmap == key_bitmap) && (count == key_count);
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      bitmap <= key_bitmap;
      count  <= key_count;
    end
  end

  // An earlier cell that matched keeps its number; otherwise this one claims it.
  always_comb begin
    chain_out.found  = chain_in.found | hit;
    chain_out.number = chain_in.found ? chain_in.number :
                       (hit ? sdt_pkg::ENTRY_W'(CELL_INDEX) : '0);
  end

endmodule

// ===== src/set_dedup_table.sv =====
// Top level of the set deduplication table: group builder, a row of entry
// cells with a priority chain, controller and result register. Depends on sdt_pkg.
//
//   Channel   Direction  Handshake                    Payload
//   member    in         member_valid / member_ready  member_index, last_member, empty_group
//   result    out        result_valid / result_ready  set_number, newly_stored,
//                                                     no_members, table_full
//
// Timing: member beats that are not the last of a group are taken one per
// cycle while the controller collects. After the last beat of a non-empty
// group the cells register their compare in the lookup state; in the resolve
// state the priority chain resolves and the result register loads, waiting
// while it is full. An empty-group beat is loaded into the result register at
// the edge that accepts it, so its result is offered from the next cycle.
// Reset clears the controller, the builder, the fill count and every cell's
// valid flag at once; there is no clearing pass. A full result register stalls
// empty-group beats and the resolve step; member beats are taken only while collecting.
module set_dedup_table #(
  parameter int unsigned MEMBER_LIMIT = 64,
  parameter int unsigned TABLE_DEPTH  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        member_valid,
  output logic                        member_ready,
  input  logic [5:0]                  member_index,
  input  logic                        last_member,
  input  logic                        empty_group,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [sdt_pkg::NUM_W-1:0]   set_number,
  output logic                        newly_stored,
  output logic                        no_members,
  output logic                        table_full
);

  localparam int unsigned USED_W = $clog2(TABLE_DEPTH + 1);

  sdt_pkg::state_t state, state_next;

  logic                        in_beat;
  logic                        slot_free;
  logic                        resolve_go;
  logic                        load;
  logic                        store;
  logic                        full;
  logic                        builder_clear;
  logic                        member_beat;
  logic [USED_W-1:0]           entries_used;
  logic [MEMBER_LIMIT-1:0]     key_bitmap;
  logic [sdt_pkg::COUNT_W-1:0] key_count;
  logic [TABLE_DEPTH-1:0]      write_sel;
  logic [sdt_pkg::ENTRY_W-1:0] used_num;

  logic [sdt_pkg::NUM_W-1:0]   number_next;
  logic                        stored_next;
  logic                        none_next;
  logic                        full_next;

  sdt_pkg::chain_t chain [TABLE_DEPTH+1];

  // The result register is free when empty or being drained this cycle.
  assign slot_free    = !result_valid || result_ready;
  // An empty-group beat needs the result register at once; member beats do not.
  assign member_ready = (state == sdt_pkg::ST_COLLECT) && (!empty_group || slot_free);
  assign in_beat      = member_valid && member_ready;
  assign member_beat  = in_beat && !empty_group;

  assign full       = (entries_used == USED_W'(TABLE_DEPTH));
  assign resolve_go = (state == sdt_pkg::ST_RESOLVE) && slot_free;
  assign store      = resolve_go && !chain[TABLE_DEPTH].found && !full;
  assign load       = (in_beat && empty_group) || resolve_go;

  // Any partly built group is dropped by an empty-group beat.
  assign builder_clear = (in_beat && empty_group) || resolve_go;

  assign used_num = sdt_pkg::ENTRY_W'(entries_used);

  sdt_builder #(
    .MEMBER_LIMIT(MEMBER_LIMIT)
  ) u_builder (
    .clk         (clk),
    .rst         (rst),
    .beat        (member_beat),
    .member_index(member_index),
    .clear       (builder_clear),
    .bitmap      (key_bitmap),
    .count       (key_count)
  );

  // The chain starts with no match; each cell passes on the lowest hit so far.
  assign chain[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign write_sel[i] = store && (entries_used == USED_W'(i));

    sdt_cell #(
      .MEMBER_LIMIT(MEMBER_LIMIT),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .key_bitmap(key_bitmap),
      .key_count (key_count),
      .write_en  (write_sel[i]),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  // Controller: collect beats, let the cells register their compare, resolve.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdt_pkg::ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sdt_pkg::ST_COLLECT: begin
        if (member_beat && last_member) begin
          state_next = sdt_pkg::ST_LOOKUP;
        end
      end
      sdt_pkg::ST_LOOKUP: begin
        state_next = sdt_pkg::ST_RESOLVE;
      end
      sdt_pkg::ST_RESOLVE: begin
        if (slot_free) begin
          state_next = sdt_pkg::ST_COLLECT;
        end
      end
      default: begin
        state_next = sdt_pkg::ST_COLLECT;
      end
    endcase
  end

  // Fill count: entries below it hold stored sets.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
    end else if (store) begin
      entries_used <= entries_used + 1'b1;
    end
  end

  // Result payload: a match, a new entry, a full table, or an empty group.
  always_comb begin
    number_next = '0;
    stored_next = 1'b0;
    none_next   = 1'b0;
    full_next   = 1'b0;
    if (state != sdt_pkg::ST_RESOLVE) begin
      none_next = 1'b1;
    end else if (chain[TABLE_DEPTH].found) begin
      number_next = chain[TABLE_DEPTH].number[sdt_pkg::NUM_W-1:0];
    end else if (!full) begin
      number_next = used_num[sdt_pkg::NUM_W-1:0];
      stored_next = 1'b1;
    end else begin
      full_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      set_number   <= number_next;
      newly_stored <= stored_next;
      no_members   <= none_next;
      table_full   <= full_next;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for set_dedup_table: drives member beats and
// predicts every lookup-or-insert outcome with its own model of the table.
// Depends on sdt_pkg and the set_dedup_table RTL.
module testbench;

  localparam int unsigned MEMBER_LIMIT = 64;
  localparam int unsigned TABLE_DEPTH  = 32;
  localparam int unsigned NUM_W        = sdt_pkg::NUM_W;
  localparam int unsigned CNT_W        = sdt_pkg::COUNT_W;

  // Total number of member beats after which the random part stops.
  localparam int unsigned BEAT_TARGET  = 1200;
  // Cycles without any accepted beat on either channel before giving up.
  localparam int unsigned IDLE_LIMIT   = 2000;
  // Length of the long receiver hold-off in the back-pressure test.
  localparam int unsigned HOLD_CYCLES  = 300;
  // Only the first few mismatches are printed; all are counted.
  localparam int unsigned PRINT_LIMIT  = 40;
  // Sets with more member beats than this are not kept for replay.
  localparam int unsigned REPLAY_MAX   = 16;

  // One result beat, field by field.
  typedef struct packed {
    logic [NUM_W-1:0] set_number;
    logic             newly_stored;
    logic             no_members;
    logic             table_full;
  } outcome_t;

  // A member set by its bitmap and its member-beat count, kept for replay.
  typedef struct {
    logic [63:0] bits;
    int unsigned count;
  } member_set_t;

  // Kinds of group that the random part draws from.
  typedef enum int unsigned {
    GRP_REPLAY,
    GRP_NEAR,
    GRP_FRESH,
    GRP_EMPTY,
    GRP_BROKEN
  } group_kind_t;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             member_valid = 1'b0;
  logic             member_ready;
  logic [5:0]       member_index = '0;
  logic             last_member  = 1'b0;
  logic             empty_group  = 1'b0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  logic [NUM_W-1:0] set_number;
  logic             newly_stored;
  logic             no_members;
  logic             table_full;

  set_dedup_table #(
    .MEMBER_LIMIT(MEMBER_LIMIT),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .member_valid(member_valid),
    .member_ready(member_ready),
    .member_index(member_index),
    .last_member (last_member),
    .empty_group (empty_group),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .set_number  (set_number),
    .newly_stored(newly_stored),
    .no_members  (no_members),
    .table_full  (table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: the group being built and the table of stored sets.
  // Stored entries above the fill count are never looked at, so they need no
  // initial value.
  // ---------------------------------------------------------------------------
  logic [63:0]      acc_bitmap = '0;
  logic [CNT_W-1:0] acc_count  = '0;
  logic [63:0]      tbl_bitmap [TABLE_DEPTH];
  logic [CNT_W-1:0] tbl_count  [TABLE_DEPTH];
  int unsigned      tbl_used   = 0;

  outcome_t         awaited_outcomes [$];
  member_set_t      sent_sets [$];
  int unsigned      fail_count     = 0;
  int unsigned      beats_sent     = 0;
  int unsigned      idle_cycles    = 0;
  int unsigned      recv_hold      = 0;
  bit               sender_idle_on = 1'b1;

  // Applies one member beat to the predicted state. Returns 1 when the beat
  // closes a group (or is an empty group), with the expected result in res.
  function automatic bit beat_outcome(input logic [5:0] idx, input logic last,
                                      input logic empty, output outcome_t res);
    int unsigned e;
    int unsigned hit;
    bit          found;
    res   = '0;
    found = 1'b0;
    hit   = 0;
    // An empty group throws away whatever was half built, whatever the
    // last marker says.
    if (empty) begin
      acc_bitmap     = '0;
      acc_count      = '0;
      res.no_members = 1'b1;
      return 1'b1;
    end
    if (idx < MEMBER_LIMIT) acc_bitmap[idx] = 1'b1;
    // The count goes on rising for repeated members and saturates at its top.
    if (acc_count != sdt_pkg::COUNT_MAX) acc_count = acc_count + 1'b1;
    if (!last) return 1'b0;
    // Lowest-numbered entry with both bitmap and count equal wins.
    for (e = 0; e < tbl_used; e++) begin
      if (!found && tbl_bitmap[e] == acc_bitmap && tbl_count[e] == acc_count) begin
        found = 1'b1;
        hit   = e;
      end
    end
    if (found) begin
      res.set_number = hit[NUM_W-1:0];
    end else if (tbl_used < TABLE_DEPTH) begin
      tbl_bitmap[tbl_used] = acc_bitmap;
      tbl_count[tbl_used]  = acc_count;
      res.set_number       = tbl_used[NUM_W-1:0];
      res.newly_stored     = 1'b1;
      tbl_used++;
    end else begin
      // A new set with no free entry: flagged, nothing stored, number zero.
      res.table_full = 1'b1;
    end
    acc_bitmap = '0;
    acc_count  = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < PRINT_LIMIT)
      $display("mismatch at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard. Everything is sampled at the rising edge, so it sees the values
  // from before the edge: inputs are driven and outputs updated by nonblocking
  // assignments. The result side is checked before the member side is
  // predicted, so a stray result can never consume a fresh expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    outcome_t want;
    outcome_t got;
    if (!rst) begin
      if (result_valid && result_ready) begin
        got = '{set_number, newly_stored, no_members, table_full};
        if (awaited_outcomes.size() == 0) begin
          report_mismatch("result beat with nothing awaited", int'(got), 0);
        end else begin
          want = awaited_outcomes.pop_front();
          if (got.set_number !== want.set_number)
            report_mismatch("set_number", int'(got.set_number), int'(want.set_number));
          if (got.newly_stored !== want.newly_stored)
            report_mismatch("newly_stored", int'(got.newly_stored),
                            int'(want.newly_stored));
          if (got.no_members !== want.no_members)
            report_mismatch("no_members", int'(got.no_members), int'(want.no_members));
          if (got.table_full !== want.table_full)
            report_mismatch("table_full", int'(got.table_full), int'(want.table_full));
        end
      end
      if (member_valid && member_ready) begin
        if (beat_outcome(member_index, last_member, empty_group, want))
          awaited_outcomes.push_back(want);
      end
    end
  end

  // Watchdog: a run in which nothing moves on either channel for too long
  // has hung.
  always @(posedge clk) begin
    if (rst || (member_valid && member_ready) || (result_valid && result_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("set_dedup_table regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver. For every beat it draws a random stall, and it switches now
  // and then between stalling and taking beats back to back. A hold request from
  // a test drops ready for a long, counted stretch.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    bit          stalls_on;
    stalls_on = 1'b1;
    wait (rst == 1'b0);
    forever begin
      if (recv_hold != 0) begin
        result_ready <= 1'b0;
        repeat (recv_hold) @(posedge clk);
        recv_hold = 0;
      end
      if ($urandom_range(0, 15) == 0) stalls_on = !stalls_on;
      stall = stalls_on ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready) && recv_hold == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge that accepts the beat.
  // Valid is only lowered when a gap is drawn, so back-to-back beats never see
  // valid dropped and raised in one time step.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [5:0] idx, input logic last, input logic empty);
    int unsigned gap;
    gap = sender_idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      member_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    member_valid <= 1'b1;
    member_index <= idx;
    last_member  <= last;
    empty_group  <= empty;
    do @(posedge clk); while (!(member_valid && member_ready));
    beats_sent++;
  endtask

  // Sends a group whose bitmap is bits and whose beat count is count: every
  // member once, then repeats of members until the count is reached, all in a
  // shuffled order. The caller keeps count at or above the number of members.
  task automatic send_group(input logic [63:0] bits, input int unsigned count);
    logic [5:0]  order [$];
    logic [5:0]  swap;
    int unsigned b;
    int unsigned k;
    for (b = 0; b < 64; b++)
      if (bits[b]) order.push_back(b[5:0]);
    while (order.size() < count)
      order.push_back(order[$urandom_range(0, order.size() - 1)]);
    for (b = order.size() - 1; b > 0; b--) begin
      k        = $urandom_range(0, b);
      swap     = order[b];
      order[b] = order[k];
      order[k] = swap;
    end
    for (b = 0; b < order.size(); b++)
      send_beat(order[b], b == order.size() - 1, 1'b0);
  endtask

  task automatic remember_set(input member_set_t s);
    if (s.count <= REPLAY_MAX) sent_sets.push_back(s);
  endtask

  // The sender stops offering and waits until every awaited result has been
  // taken. Always waits for a clock edge first so valid is not driven twice in
  // one step.
  task automatic wait_drained();
    member_valid <= 1'b0;
    do @(posedge clk); while (awaited_outcomes.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes of the index, hits and misses, repeated members, empty groups
  // with either marker, and an empty group cutting a half-built group short.
  task automatic test_directed();
    send_beat(6'd0,  1'b1, 1'b0);   // first set stored as entry 0
    send_beat(6'd63, 1'b1, 1'b0);   // top index, new entry
    send_beat(6'd63, 1'b1, 1'b0);   // same set again: a hit
    send_beat(6'd7,  1'b0, 1'b0);   // a repeated member counts twice...
    send_beat(6'd7,  1'b1, 1'b0);
    send_beat(6'd7,  1'b1, 1'b0);   // ...so one 7 alone is a different set
    send_beat(6'd12, 1'b1, 1'b1);   // empty group with the last marker
    send_beat(6'd40, 1'b0, 1'b1);   // empty group without it
    send_beat(6'd3,  1'b0, 1'b0);   // half-built group...
    send_beat(6'd4,  1'b0, 1'b0);
    send_beat(6'd9,  1'b0, 1'b1);   // ...thrown away by an empty group
    send_beat(6'd5,  1'b1, 1'b0);   // must not carry members 3 and 4
    send_beat(6'd5,  1'b1, 1'b0);
    send_beat(6'd0,  1'b0, 1'b0);   // both extremes together
    send_beat(6'd63, 1'b1, 1'b0);
    send_beat(6'd63, 1'b0, 1'b0);   // same set in the other order: a hit
    send_beat(6'd0,  1'b1, 1'b0);
  endtask

  // The member count saturates: 130 and 127 beats of one member give the
  // same set, 126 beats do not.
  task automatic test_count_saturation();
    logic [63:0] bits;
    bits     = '0;
    bits[9]  = 1'b1;
    send_group(bits, 130);
    send_group(bits, 127);
    send_group(bits, 126);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // short groups back to back, so the result register fills and the block
  // stalls its input.
  task automatic test_backpressure();
    logic [63:0] bits;
    int unsigned n;
    wait_drained();
    sender_idle_on = 1'b0;
    recv_hold      = HOLD_CYCLES;
    repeat (10) begin
      bits = '0;
      n    = $urandom_range(1, 4);
      repeat (n) bits[$urandom_range(0, 63)] = 1'b1;
      send_group(bits, $countones(bits));
      send_beat(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 1'b1);
    end
    sender_idle_on = 1'b1;
    wait_drained();
  endtask

  // Fills every free entry with sets of three beats on one member, then offers
  // new sets that find no free entry, then replays a stored one.
  task automatic test_table_full();
    logic [63:0] bits;
    int unsigned j;
    j = 0;
    while (tbl_used < TABLE_DEPTH) begin
      bits    = '0;
      bits[j] = 1'b1;
      send_group(bits, 3);
      j++;
    end
    // Nine beats over two members: no set like this has been stored.
    repeat (4) begin
      bits = '0;
      bits[$urandom_range(0, 31)]  = 1'b1;
      bits[$urandom_range(32, 63)] = 1'b1;
      send_group(bits, 9);
    end
    bits    = '0;
    bits[0] = 1'b1;
    send_group(bits, 3);
  endtask

  // Mostly well-formed groups with random content: replays of earlier sets
  // (hits), near misses that differ in one member or in the count, and fresh
  // sets; the rest are empty groups and groups broken off by an empty group.
  task automatic test_random_groups();
    group_kind_t kind;
    member_set_t s;
    int unsigned r;
    int unsigned n;
    int unsigned b;
    bit          narrow;
    while (beats_sent < BEAT_TARGET) begin
      if ($urandom_range(0, 7) == 0) sender_idle_on = !sender_idle_on;
      if ($urandom_range(0, 39) == 0) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 40)      kind = GRP_REPLAY;
      else if (r < 55) kind = GRP_NEAR;
      else if (r < 80) kind = GRP_FRESH;
      else if (r < 90) kind = GRP_EMPTY;
      else             kind = GRP_BROKEN;
      if (sent_sets.size() == 0 && (kind == GRP_REPLAY || kind == GRP_NEAR))
        kind = GRP_FRESH;
      case (kind)
        GRP_REPLAY: begin
          s = sent_sets[$urandom_range(0, sent_sets.size() - 1)];
          send_group(s.bits, s.count);
        end
        GRP_NEAR: begin
          s = sent_sets[$urandom_range(0, sent_sets.size() - 1)];
          if ($urandom_range(0, 1) == 0) begin
            s.count++;
          end else begin
            b         = $urandom_range(0, 63);
            s.bits[b] = !s.bits[b];
            if (s.bits == '0) begin
              s.bits[b] = 1'b1;
              s.count++;
            end
            if ($countones(s.bits) > s.count) s.count = $countones(s.bits);
          end
          send_group(s.bits, s.count);
          remember_set(s);
        end
        GRP_FRESH: begin
          // A narrow index range makes repeated members and hits likelier.
          narrow  = 1'($urandom_range(0, 1));
          n       = $urandom_range(1, 10);
          s.bits  = '0;
          s.count = n;
          repeat (n) s.bits[narrow ? $urandom_range(0, 7) : $urandom_range(0, 63)] = 1'b1;
          send_group(s.bits, s.count);
          remember_set(s);
        end
        GRP_EMPTY: begin
          send_beat(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 1'b1);
        end
        default: begin
          n = $urandom_range(1, 4);
          repeat (n) send_beat(6'($urandom_range(0, 63)), 1'b0, 1'b0);
          send_beat(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 1'b1);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: one reset, the tests in turn, then drain and give the verdict.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_count_saturation();
    test_backpressure();
    test_table_full();
    test_random_groups();
    wait_drained();
    // The deepest pipeline path runs through the lookup and resolve states
    // after a group's last beat; the wait catches any result the block should not send.
    repeat (10) @(posedge clk);
    if (fail_count == 0 && awaited_outcomes.size() == 0) begin
      $display("set_dedup_table regression: pass");
    end else begin
      $display("set_dedup_table regression: fail");
    end
    $finish;
  end

endmodule
